@@ rtl/pidat_pkg.sv @@
// ----------------------------------------------------------------------------
// pidat_pkg - shared definitions for the PID gain autotuner
// Constants, configuration and queue entry types, item kinds and register
// indexes used across the front end, the queue and the tuning back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pidat_pkg;

   localparam int AXES        = 3;
   localparam int AXIS_W      = 2;
   localparam int ERR_W       = 14;
   localparam int THR_W       = 11;
   localparam int PG_W        = 8;
   localparam int IG_W        = 7;
   localparam int CSR_W       = 11;
   localparam int P_LIMIT     = 200;
   localparam int I_LIMIT     = 100;
   localparam int I_CAP       = (I_LIMIT < 127) ? I_LIMIT : 127;
   localparam int HOLD_MARGIN = 250;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Axis limit widened by one bit so that any value up to seven compares cleanly
   localparam logic [AXIS_W:0] AXES_LIM = (AXIS_W + 1)'(AXES);

   typedef enum logic [2:0] {
      CSR_SKIP_PERIOD      = 3'd0,
      CSR_AVG_SAMPLES      = 3'd1,
      CSR_I_THRESHOLD      = 3'd2,
      CSR_P_RISE_THRESHOLD = 3'd3,
      CSR_P_FALL_THRESHOLD = 3'd4,
      CSR_THROTTLE_FLOOR   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_OUT_OF_RANGE = 2'd0,
      KIND_SKIP         = 2'd1,
      KIND_AVERAGE      = 2'd2,
      KIND_ADJUST       = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]       skip_period;
      logic [7:0]       avg_samples;
      logic [7:0]       i_threshold;
      logic [7:0]       p_rise_threshold;
      logic [7:0]       p_fall_threshold;
      logic [THR_W-1:0] throttle_floor;
   } cfg_type;

   typedef struct packed {
      logic [AXIS_W-1:0]       axis;
      logic signed [ERR_W-1:0] error;
      logic [THR_W-1:0]        throttle;
      kind_type                kind;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

@@ rtl/pidat_front.sv @@
// ----------------------------------------------------------------------------
// pidat_front - input classification
// Accepts request transactions, runs the shared skip and sample counters and
// tags each item with the action the back end must carry out.
// ----------------------------------------------------------------------------
`default_nettype none

module pidat_front
   import pidat_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [AXIS_W-1:0]       req_axis,
   input  wire logic signed [ERR_W-1:0] req_error,
   input  wire logic [THR_W-1:0]        req_throttle,
   input  wire q_status_type            q_status,
   output logic                         q_push,
   output q_entry_type                  q_wdata
);

   logic [7:0] skip_count_ff, skip_count_in;
   logic [7:0] sample_count_ff, sample_count_in;
   logic       axis0;
   kind_type   kind;

   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;
   assign axis0      = (req_axis == '0);

   always_comb begin
      skip_count_in   = skip_count_ff;
      sample_count_in = sample_count_ff;
      kind            = KIND_OUT_OF_RANGE;
      if ({1'b0, req_axis} >= AXES_LIM) begin
         kind = KIND_OUT_OF_RANGE;
      end else if (skip_count_ff < cfg.skip_period) begin
         kind = KIND_SKIP;
         if (axis0) begin
            skip_count_in = skip_count_ff + 8'd1;
         end
      end else begin
         if (axis0) begin
            skip_count_in = '0;
         end
         if (sample_count_ff < cfg.avg_samples) begin
            kind = KIND_AVERAGE;
            if (axis0) begin
               sample_count_in = sample_count_ff + 8'd1;
            end
         end else begin
            kind = KIND_ADJUST;
            if (axis0) begin
               sample_count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff   <= '0;
         sample_count_ff <= '0;
      end else if (q_push) begin
         skip_count_ff   <= skip_count_in;
         sample_count_ff <= sample_count_in;
      end
   end

   assign q_wdata.axis     = req_axis;
   assign q_wdata.error    = req_error;
   assign q_wdata.throttle = req_throttle;
   assign q_wdata.kind     = kind;

endmodule

`default_nettype wire

@@ rtl/pidat_fifo.sv @@
// ----------------------------------------------------------------------------
// pidat_fifo - classified item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pidat_fifo
   import pidat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_push,
   input  wire q_entry_type q_wdata,
   input  wire logic        q_pop,
   output q_entry_type      q_rdata,
   output q_status_type     q_status
);

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_rdata        = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !q_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pidat_back.sv @@
// ----------------------------------------------------------------------------
// pidat_back - per-axis tuning engine
// Pops classified items, updates the per-axis average, gains and held copies
// and registers one response transaction per item.
// ----------------------------------------------------------------------------
`default_nettype none

module pidat_back
   import pidat_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire q_entry_type   q_rdata,
   input  wire q_status_type  q_status,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic               rsp_tuned,
   output logic [PG_W-1:0]    rsp_p_gain,
   output logic [IG_W-1:0]    rsp_i_gain,
   output logic [PG_W-1:0]    rsp_held_p,
   output logic [IG_W-1:0]    rsp_held_i
);

   logic signed [ERR_W-1:0] avg_ff  [AXES];
   logic signed [ERR_W-1:0] prev_ff [AXES];
   logic [PG_W-1:0]         pg_ff   [AXES];
   logic [IG_W-1:0]         ig_ff   [AXES];
   logic [PG_W-1:0]         hp_ff   [AXES];
   logic [IG_W-1:0]         hi_ff   [AXES];

   logic                    rsp_valid_ff;
   logic                    tuned_ff, tuned_in;
   logic [PG_W-1:0]         p_out_ff, p_out_in;
   logic [IG_W-1:0]         i_out_ff, i_out_in;
   logic [PG_W-1:0]         hp_out_ff, hp_out_in;
   logic [IG_W-1:0]         hi_out_ff, hi_out_in;

   logic [AXIS_W-1:0]       idx;
   logic                    in_range, processed, adjust, hold;
   logic signed [ERR_W-1:0] err, avg_cur, old, avg_in;
   logic signed [ERR_W:0]   sum, half;
   logic [ERR_W-1:0]        avg_mag, err_mag, old_mag;
   logic signed [ERR_W:0]   diff, rise_lim, fall_lim;
   logic                    err_nonneg, err_nonpos, old_nonneg, old_nonpos, same_sign;
   logic [PG_W-1:0]         pg_cur, pg_in;
   logic [IG_W-1:0]         ig_cur, ig_step, ig_in;
   logic [THR_W:0]          hold_lim;

   assign q_pop = !q_status.empty && (!rsp_valid_ff || rsp_tready);

   assign in_range  = (q_rdata.kind != KIND_OUT_OF_RANGE);
   assign processed = (q_rdata.kind == KIND_AVERAGE) || (q_rdata.kind == KIND_ADJUST);
   assign adjust    = (q_rdata.kind == KIND_ADJUST);
   // Park the index on axis 0 for out-of-range items so no read leaves the array
   assign idx       = in_range ? q_rdata.axis : '0;
   assign err       = q_rdata.error;
   assign avg_cur   = avg_ff[idx];
   assign old       = prev_ff[idx];
   assign pg_cur    = pg_ff[idx];
   assign ig_cur    = ig_ff[idx];

   // Running average, halved with truncation toward zero
   assign sum  = {avg_cur[ERR_W-1], avg_cur} + {err[ERR_W-1], err};
   assign half = (sum + {{ERR_W{1'b0}}, sum[ERR_W]}) >>> 1;

   assign avg_mag = avg_cur[ERR_W-1] ? ERR_W'(-avg_cur) : avg_cur;
   assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : err;
   assign old_mag = old[ERR_W-1] ? ERR_W'(-old) : old;

   always_comb begin
      ig_step = ig_cur;
      if (avg_mag > {{(ERR_W-8){1'b0}}, cfg.i_threshold}) begin
         if (ig_cur < IG_W'(I_CAP)) begin
            ig_step = ig_cur + IG_W'(1);
         end
      end else if (ig_cur != '0) begin
         ig_step = ig_cur - IG_W'(1);
      end
   end

   assign ig_in  = adjust ? ig_step : ig_cur;
   assign avg_in = adjust ? '0 : ERR_W'(half);

   // Zero counts as either sign
   assign err_nonneg = !err[ERR_W-1];
   assign err_nonpos = err[ERR_W-1] || (err == '0);
   assign old_nonneg = !old[ERR_W-1];
   assign old_nonpos = old[ERR_W-1] || (old == '0);
   assign same_sign  = (err_nonneg && old_nonneg) || (err_nonpos && old_nonpos);

   assign diff     = $signed({1'b0, err_mag}) - $signed({1'b0, old_mag});
   assign rise_lim = $signed({{(ERR_W-7){1'b0}}, cfg.p_rise_threshold});
   assign fall_lim = -$signed({{(ERR_W-7){1'b0}}, cfg.p_fall_threshold});

   always_comb begin
      pg_in = pg_cur;
      if (same_sign) begin
         if (diff > rise_lim) begin
            if (pg_cur < PG_W'(P_LIMIT)) begin
               pg_in = pg_cur + PG_W'(1);
            end
         end else if (diff < fall_lim) begin
            if (pg_cur != '0) begin
               pg_in = pg_cur - PG_W'(1);
            end
         end
      end
   end

   assign hold_lim = {1'b0, cfg.throttle_floor} + (THR_W + 1)'(HOLD_MARGIN);
   assign hold     = ({1'b0, q_rdata.throttle} > hold_lim);

   always_comb begin
      tuned_in  = processed;
      p_out_in  = '0;
      i_out_in  = '0;
      hp_out_in = '0;
      hi_out_in = '0;
      if (processed) begin
         p_out_in  = pg_in;
         i_out_in  = ig_in;
         hp_out_in = hold ? pg_in : hp_ff[idx];
         hi_out_in = hold ? ig_in : hi_ff[idx];
      end else if (in_range) begin
         p_out_in  = pg_cur;
         i_out_in  = ig_cur;
         hp_out_in = hp_ff[idx];
         hi_out_in = hi_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AXES; k++) begin
            avg_ff[k]  <= '0;
            prev_ff[k] <= '0;
            pg_ff[k]   <= '0;
            ig_ff[k]   <= '0;
            hp_ff[k]   <= '0;
            hi_ff[k]   <= '0;
         end
      end else if (q_pop && processed) begin
         for (int k = 0; k < AXES; k++) begin
            if (idx == AXIS_W'(k)) begin
               avg_ff[k]  <= avg_in;
               prev_ff[k] <= err;
               pg_ff[k]   <= pg_in;
               ig_ff[k]   <= ig_in;
               if (hold) begin
                  hp_ff[k] <= pg_in;
                  hi_ff[k] <= ig_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold the response payload until the next item is popped
   always_ff @(posedge clock) begin
      if (q_pop) begin
         tuned_ff  <= tuned_in;
         p_out_ff  <= p_out_in;
         i_out_ff  <= i_out_in;
         hp_out_ff <= hp_out_in;
         hi_out_ff <= hi_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuned  = tuned_ff;
   assign rsp_p_gain = p_out_ff;
   assign rsp_i_gain = i_out_ff;
   assign rsp_held_p = hp_out_ff;
   assign rsp_held_i = hi_out_ff;

endmodule

`default_nettype wire

@@ rtl/pid_gain_autotuner.sv @@
// ----------------------------------------------------------------------------
// pid_gain_autotuner - per-axis P and I gain autotuner
// Classifies axis error samples, then steps P and I gains per axis and keeps
// held copies of them while the throttle is high.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock while the queue is not
// full and returns exactly one response transaction per request, in order. The
// front end runs the shared skip and sample counters at acceptance and queues
// the tagged item in a four-entry queue; the back end does the per-axis update
// and registers the result. Sustained rate is one item per cycle while the
// response side accepts, limited by the read-modify-write of the per-axis gain
// registers; the queue absorbs up to four items while the response side stalls.
// The user must write registers through the csr port only while no transaction
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_gain_autotuner
   import pidat_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [31:0]      req_tdata,  // error[13:0], throttle[24:14], zero pad
   input  wire logic [1:0]       req_tuser,  // axis[1:0]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [31:0]           rsp_tdata,  // p_gain[7:0], i_gain[14:8],
                                             // held_p[22:15], held_i[29:23], zero pad
   output logic                  rsp_tuser   // tuned
);

   cfg_type      cfg_ff;
   q_entry_type  q_wdata, q_rdata;
   q_status_type q_status;
   logic         q_push, q_pop;
   logic         rsp_tuned;
   logic [PG_W-1:0] rsp_p_gain, rsp_held_p;
   logic [IG_W-1:0] rsp_i_gain, rsp_held_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.skip_period      <= '0;
         cfg_ff.avg_samples      <= '0;
         cfg_ff.i_threshold      <= '0;
         cfg_ff.p_rise_threshold <= '0;
         cfg_ff.p_fall_threshold <= '0;
         cfg_ff.throttle_floor   <= THR_W'(1400);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SKIP_PERIOD:      cfg_ff.skip_period      <= csr_wdata[7:0];
            CSR_AVG_SAMPLES:      cfg_ff.avg_samples      <= csr_wdata[7:0];
            CSR_I_THRESHOLD:      cfg_ff.i_threshold      <= csr_wdata[7:0];
            CSR_P_RISE_THRESHOLD: cfg_ff.p_rise_threshold <= csr_wdata[7:0];
            CSR_P_FALL_THRESHOLD: cfg_ff.p_fall_threshold <= csr_wdata[7:0];
            CSR_THROTTLE_FLOOR:   cfg_ff.throttle_floor   <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   pidat_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_axis     (req_tuser),
      .req_error    ($signed(req_tdata[ERR_W-1:0])),
      .req_throttle (req_tdata[ERR_W+THR_W-1:ERR_W]),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_wdata      (q_wdata)
   );

   pidat_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_wdata  (q_wdata),
      .q_pop    (q_pop),
      .q_rdata  (q_rdata),
      .q_status (q_status)
   );

   pidat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_rdata    (q_rdata),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuned  (rsp_tuned),
      .rsp_p_gain (rsp_p_gain),
      .rsp_i_gain (rsp_i_gain),
      .rsp_held_p (rsp_held_p),
      .rsp_held_i (rsp_held_i)
   );

   assign rsp_tdata = {2'b00, rsp_held_i, rsp_held_p, rsp_i_gain, rsp_p_gain};
   assign rsp_tuser = rsp_tuned;

   // A full queue must never take another transaction
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("queue overflow");

   // Popping an empty queue would invent a response
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("queue underflow");

   // Every popped item shows up as a pending response on the next cycle
   assert property (@(posedge clock) disable iff (reset) q_pop |=> rsp_tvalid)
      else $error("popped item produced no response");

   // A skipped or out-of-range item never reports itself as tuned
   assert property (@(posedge clock) disable iff (reset)
      q_pop && (q_rdata.kind == KIND_SKIP || q_rdata.kind == KIND_OUT_OF_RANGE)
      |=> !rsp_tuser)
      else $error("untuned item flagged as tuned");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - PID gain autotuner stream test
// Drives axis error samples through the request stream and rewrites the six
// tuning registers between phases. A gain tracker keeps its own copy of the
// skip and sample counters and the per-axis gains, predicts every response and
// compares it field by field. Idle gaps and receiver stalls vary within each
// phase, and phase two adds one long hold-off.
// ----------------------------------------------------------------------------

import pidat_pkg::*;

typedef struct packed {
   logic            tuned;
   logic [PG_W-1:0] p_gain;
   logic [IG_W-1:0] i_gain;
   logic [PG_W-1:0] held_p;
   logic [IG_W-1:0] held_i;
} gain_report_type;

typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

class gain_tracker;
   cfg_type         settings;
   int              skip_count;
   int              sample_count;
   int              avg_error [AXES];
   int              prev_error [AXES];
   int              p_gain [AXES];
   int              i_gain [AXES];
   int              held_p [AXES];
   int              held_i [AXES];
   gain_report_type awaited [$];
   int              mismatches;
   int              requests;
   int              tuned_count;
   int              skipped_count;
   int              ignored_count;
   int              peak_p;
   int              peak_i;

   function new();
      settings = '0;
      settings.throttle_floor = THR_W'(1400);
      skip_count = 0;
      sample_count = 0;
      for (int k = 0; k < AXES; k++) begin
         avg_error[k] = 0;
         prev_error[k] = 0;
         p_gain[k] = 0;
         i_gain[k] = 0;
         held_p[k] = 0;
         held_i[k] = 0;
      end
      mismatches = 0;
      requests = 0;
      tuned_count = 0;
      skipped_count = 0;
      ignored_count = 0;
      peak_p = 0;
      peak_i = 0;
   endfunction

   static function int magnitude(int x);
      return (x < 0) ? -x : x;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   function void write_register(csr_index_type idx, logic [CSR_W-1:0] value);
      case (idx)
         CSR_SKIP_PERIOD:      settings.skip_period = value[7:0];
         CSR_AVG_SAMPLES:      settings.avg_samples = value[7:0];
         CSR_I_THRESHOLD:      settings.i_threshold = value[7:0];
         CSR_P_RISE_THRESHOLD: settings.p_rise_threshold = value[7:0];
         CSR_P_FALL_THRESHOLD: settings.p_fall_threshold = value[7:0];
         CSR_THROTTLE_FLOOR:   settings.throttle_floor = value[THR_W-1:0];
         default: ;
      endcase
   endfunction

   // Work out the gains that one accepted sample leaves behind
   function void note_sample(logic [AXIS_W-1:0] axis, logic [ERR_W-1:0] err,
                             logic [THR_W-1:0] thr);
      gain_report_type r;
      int e;
      int old;
      int diff;
      int rise;
      int fall;
      r = '0;
      e = $signed(err);
      rise = settings.p_rise_threshold;
      fall = settings.p_fall_threshold;
      requests++;
      if (axis >= AXES) begin
         ignored_count++;
         awaited.push_back(r);
         return;
      end
      if (skip_count < settings.skip_period) begin
         if (axis == 0) skip_count++;
         skipped_count++;
      end else begin
         if (axis == 0) skip_count = 0;
         if (sample_count < settings.avg_samples) begin
            avg_error[axis] = (avg_error[axis] + e) / 2;
            if (axis == 0) sample_count++;
         end else begin
            if (magnitude(avg_error[axis]) > int'(settings.i_threshold)) begin
               if (i_gain[axis] < I_CAP) i_gain[axis]++;
            end else begin
               if (i_gain[axis] > 0) i_gain[axis]--;
            end
            avg_error[axis] = 0;
            if (axis == 0) sample_count = 0;
         end
         // zero counts as either sign
         old = prev_error[axis];
         if ((e >= 0 && old >= 0) || (e <= 0 && old <= 0)) begin
            diff = magnitude(e) - magnitude(old);
            if (diff > rise) begin
               if (p_gain[axis] < P_LIMIT) p_gain[axis]++;
            end else if (diff < -fall) begin
               if (p_gain[axis] > 0) p_gain[axis]--;
            end
         end
         if (int'(thr) > int'(settings.throttle_floor) + HOLD_MARGIN) begin
            held_p[axis] = p_gain[axis];
            held_i[axis] = i_gain[axis];
         end
         prev_error[axis] = e;
         r.tuned = 1'b1;
         tuned_count++;
      end
      r.p_gain = PG_W'(p_gain[axis]);
      r.i_gain = IG_W'(i_gain[axis]);
      r.held_p = PG_W'(held_p[axis]);
      r.held_i = IG_W'(held_i[axis]);
      if (p_gain[axis] > peak_p) peak_p = p_gain[axis];
      if (i_gain[axis] > peak_i) peak_i = i_gain[axis];
      awaited.push_back(r);
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_result(logic tuned, logic [31:0] data);
      gain_report_type want;
      if (awaited.size() == 0) begin
         $error("response transaction with no request outstanding");
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      check_field("tuned", want.tuned, tuned);
      check_field("p_gain", want.p_gain, data[7:0]);
      check_field("i_gain", want.i_gain, data[14:8]);
      check_field("held_p", want.held_p, data[22:15]);
      check_field("held_i", want.held_i, data[29:23]);
   endfunction
endclass

module testbench;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 80;
   localparam int SETTLE_CYCLES  = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_SKIP_PERIOD;
   logic [CSR_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // error[13:0], throttle[24:14], zero pad
   logic [1:0]            req_tuser = '0;   // axis[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // p_gain[7:0], i_gain[14:8],
                                            // held_p[22:15], held_i[29:23], zero pad
   logic                  rsp_tuser;        // tuned

   gain_tracker gains = new();

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_trigger = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          settings_used = 0;

   // per-axis error ramps for the well-formed part of the stimulus
   int          round_order [3] = '{1, 2, 0};
   int          round_pos = 0;
   int          ramp_mag [3] = '{0, 0, 0};
   int          ramp_step [3] = '{40, 70, 100};
   bit          ramp_neg [3] = '{0, 1, 0};

   pid_gain_autotuner dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) gains.check_result(rsp_tuser, rsp_tdata);
      if (hold_trigger && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", quiet_cycles);
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
         IDLE_SENDER:   begin send_idle_pct = 61; stall_pct <= 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 61; end
         default:       begin send_idle_pct = 28; stall_pct <= 28; end
      endcase
   endtask

   task automatic send_item(logic [AXIS_W-1:0] axis, logic [ERR_W-1:0] err,
                            logic [THR_W-1:0] thr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, thr, err};
      req_tuser <= axis;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gains.note_sample(axis, err, thr);
   endtask

   task automatic send_random_item();
      logic [AXIS_W-1:0] axis;
      logic [ERR_W-1:0]  err;
      logic [THR_W-1:0]  thr;
      int                a;
      if ($urandom_range(99) < 15) begin
         // noise: any axis, any error, occasionally a throttle out of range
         axis = AXIS_W'($urandom_range(3));
         err = ERR_W'($urandom_range(16383));
         thr = ($urandom_range(9) == 0) ? THR_W'($urandom_range(2047))
                                        : THR_W'($urandom_range(2000, 1000));
      end else begin
         a = round_order[round_pos];
         round_pos = (round_pos + 1) % 3;
         ramp_mag[a] += ramp_step[a];
         if (ramp_mag[a] > 8191 || $urandom_range(99) < 3) begin
            ramp_mag[a] = $urandom_range(200);
            ramp_step[a] = $urandom_range(150, 1);
            ramp_neg[a] = $urandom_range(1);
         end
         axis = AXIS_W'(a);
         err = ramp_neg[a] ? ERR_W'(-ramp_mag[a]) : ERR_W'(ramp_mag[a]);
         thr = THR_W'($urandom_range(2000, 1000));
      end
      send_item(axis, err, thr);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      gains.write_register(idx, value);
   endtask

   task automatic apply_settings(cfg_type s);
      write_register(CSR_SKIP_PERIOD, CSR_W'(s.skip_period));
      write_register(CSR_AVG_SAMPLES, CSR_W'(s.avg_samples));
      write_register(CSR_I_THRESHOLD, CSR_W'(s.i_threshold));
      write_register(CSR_P_RISE_THRESHOLD, CSR_W'(s.p_rise_threshold));
      write_register(CSR_P_FALL_THRESHOLD, CSR_W'(s.p_fall_threshold));
      write_register(CSR_THROTTLE_FLOOR, CSR_W'(s.throttle_floor));
      csr_wr_en <= 1'b0;
      settings_used++;
      @(posedge clock);
   endtask

   // drop valid and wait until every response is back and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (gains.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int phase, int count, cfg_type s);
      settle();
      apply_settings(s);
      for (int n = 0; n < count; n++) begin
         if (n % 80 == 0) set_idling(idle_mode_type'((n / 80 + phase) % 4));
         if (phase == 2 && n == 100) hold_trigger <= 1'b1;
         send_random_item();
      end
   endtask

   initial begin
      cfg_type random_cfg;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);
      apply_settings(cfg_type'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 11'd1400});

      // directed: field extremes, sign changes, zero error, held-copy boundary
      send_item(2'd3, 14'h2000, 11'd2047);
      send_item(2'd0, 14'h1FFF, 11'd2000);
      send_item(2'd0, 14'h2000, 11'd1000);
      send_item(2'd0, 14'h0000, 11'd0);
      send_item(2'd0, 14'h0005, 11'd1651);
      send_item(2'd1, 14'h0001, 11'd1650);
      send_item(2'd1, 14'h0002, 11'd1651);
      send_item(2'd1, 14'h0003, 11'd1651);
      send_item(2'd1, 14'h3FFF, 11'd1700);
      send_item(2'd2, ERR_W'(-100), 11'd1800);
      send_item(2'd2, ERR_W'(-50), 11'd1800);
      send_item(2'd2, 14'h2000, 11'd2047);
      send_item(2'd2, 14'h1FFF, 11'd1024);
      send_item(2'd3, 14'h3FFF, 11'd1000);
      send_item(2'd1, 14'h0000, 11'd1023);
      send_item(2'd0, 14'h1555, 11'd1365);
      send_item(2'd0, 14'h2AAA, 11'd682);

      run_phase(1, 560, cfg_type'{8'd0, 8'd1, 8'd0, 8'd0, 8'd255, 11'd1000});
      run_phase(2, 160, cfg_type'{8'd2, 8'd3, 8'd100, 8'd10, 8'd10, 11'd1500});
      run_phase(3, 100, cfg_type'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 11'd2000});
      // the skip period now drops below the running skip counter
      run_phase(4, 140, cfg_type'{8'd1, 8'd2, 8'd20, 8'd5, 8'd50, 11'd1200});
      random_cfg.skip_period = 8'($urandom_range(3));
      random_cfg.avg_samples = 8'($urandom_range(255));
      random_cfg.i_threshold = 8'($urandom_range(255));
      random_cfg.p_rise_threshold = 8'($urandom_range(255));
      random_cfg.p_fall_threshold = 8'($urandom_range(255));
      random_cfg.throttle_floor = THR_W'($urandom_range(2000, 1000));
      run_phase(5, 140, random_cfg);
      settle();

      $display("covered %0d requests under %0d register settings:",
               gains.requests, settings_used);
      $display("%0d tuned, %0d skipped, %0d bad axis",
               gains.tuned_count, gains.skipped_count, gains.ignored_count);
      $display("highest P gain reached %0d, highest I gain reached %0d",
               gains.peak_p, gains.peak_i);
      if (gains.mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

@@ pid_gain_autotuner.f @@
rtl/pidat_pkg.sv
rtl/pidat_front.sv
rtl/pidat_fifo.sv
rtl/pidat_back.sv
rtl/pid_gain_autotuner.sv
test/testbench.sv
